@@ rtl/skti_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, types and codes of the sorted key table insert unit
package skti_pkg;

	localparam int DEPTH     = 256;
	localparam int KEY_W     = 64;
	localparam int WORD_W    = 64;
	localparam int IDX_IN_W  = 8;
	localparam int ENT_CNT_W = 9;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CMP_W     = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

	// cell row is read and reduced in groups of GRP cells
	localparam int GRP_W   = 4;
	localparam int GRP     = 1 << GRP_W;
	localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
	localparam int SEL_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int NGRP_P2 = 1 << SEL_W;
	localparam int RADDR_W = GRP_W + SEL_W;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_NOENT = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] w0;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		logic [WORD_W-1:0] w3;
	} entry_t;

	typedef struct packed {
		logic cmp_en;
		logic wr_en;
	} cell_ctrl_t;

	typedef struct packed {
		logic s1_en;
		logic s2_en;
		logic wr_en;
	} arr_ctrl_t;

endpackage

@@ rtl/sorted_key_table_insert_unit.sv @@
`timescale 1ns / 1ps
// top level of the sorted key table: request control, entry count and result register
//
//  channel  | valid     | stall     | beat fields
//  ---------+-----------+-----------+--------------------------------------------------
//  request  | in_valid  | in_stall  | func key payload_w0..payload_w3 index
//  result   | out_valid | out_stall | status out_key out_w0..out_w3 held_count
//
// one request is in flight at a time; a request passes the s1, s2 and s3 registers
// before the edge that loads its result, and the next request is taken at that same edge
// the stages come from the cell row: key compare in every cell, then a registered
// group stage and a final stage for the duplicate search and the indexed read
// reset clears the entry count and the pipeline valids; cell contents are not cleared
// a held result waits in the output register; input stalls while s1 or s2 is busy or s3 waits
module sorted_key_table_insert_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [63:0] key,
	input  logic [63:0] payload_w0,
	input  logic [63:0] payload_w1,
	input  logic [63:0] payload_w2,
	input  logic [63:0] payload_w3,
	input  logic [7:0]  index,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] out_key,
	output logic [63:0] out_w0,
	output logic [63:0] out_w1,
	output logic [63:0] out_w2,
	output logic [63:0] out_w3,
	output logic [8:0]  held_count
);

	// pipeline valids: s1 compare, s2 group reduce, s3 final decision
	logic                               valid_s1;
	logic                               valid_s2;
	logic                               valid_s3;

	// request beat, held until the next accept
	logic [1:0]                         func_q;
	skti_pkg::entry_t                   req_ent_q;
	logic [skti_pkg::IDX_IN_W-1:0]      index_q;

	logic [skti_pkg::CNT_W-1:0]         count_q;

	// result register
	logic                               out_valid_q;
	logic [1:0]                         status_q;
	skti_pkg::entry_t                   out_ent_q;
	logic [skti_pkg::ENT_CNT_W-1:0]     held_count_q;

	logic                               in_acc;
	logic                               commit;
	logic                               table_full;
	logic                               rd_hit;
	logic                               dup_found;
	skti_pkg::entry_t                   rd_entry;
	skti_pkg::arr_ctrl_t                arr_ctrl;
	skti_pkg::entry_t                   req_beat;

	// decision of the request in s3
	logic [1:0]                         res_status;
	skti_pkg::entry_t                   res_ent;
	logic [skti_pkg::CNT_W-1:0]         count_next;
	logic                               ins_ok;

	assign in_acc = in_valid && !in_stall;

	// s3 retires when the result register is free or being emptied
	assign commit   = valid_s3 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 || valid_s2 || (valid_s3 && !commit);

	assign table_full = (count_q == skti_pkg::CNT_W'(skti_pkg::DEPTH));
	assign rd_hit     = (skti_pkg::CMP_W'(index_q) < skti_pkg::CMP_W'(count_q));

	assign req_beat.key = key;
	assign req_beat.w0  = payload_w0;
	assign req_beat.w1  = payload_w1;
	assign req_beat.w2  = payload_w2;
	assign req_beat.w3  = payload_w3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			count_q  <= '0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 || (valid_s3 && !commit);
			if (commit) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q    <= func;
			req_ent_q <= req_beat;
			index_q   <= index;
		end
	end

	// final decision: duplicate before full, read gated by the fill count
	always_comb begin
		res_status = skti_pkg::ST_OK;
		res_ent    = '0;
		count_next = count_q;
		ins_ok     = 1'b0;
		unique case (func_q)
			skti_pkg::FUNC_INSERT: begin
				if (dup_found) begin
					res_status = skti_pkg::ST_DUP;
				end else if (table_full) begin
					res_status = skti_pkg::ST_FULL;
				end else begin
					ins_ok     = 1'b1;
					count_next = count_q + skti_pkg::CNT_W'(1);
				end
			end
			skti_pkg::FUNC_READ: begin
				if (rd_hit) begin
					res_ent = rd_entry;
				end else begin
					res_status = skti_pkg::ST_NOENT;
				end
			end
			skti_pkg::FUNC_CLEAR: begin
				count_next = '0;
			end
			default: begin
				// unused code: no operation
				res_status = skti_pkg::ST_OK;
			end
		endcase
	end

	assign arr_ctrl.s1_en = valid_s1;
	assign arr_ctrl.s2_en = valid_s2;
	assign arr_ctrl.wr_en = commit && ins_ok;

	skti_array u_array (
		.clk       (clk),
		.ctrl      (arr_ctrl),
		.count     (count_q),
		.cmp_key   (req_ent_q.key),
		.new_entry (req_ent_q),
		.rd_addr   (skti_pkg::RADDR_W'(index_q)),
		.rd_entry  (rd_entry),
		.dup_found (dup_found)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= res_status;
			out_ent_q    <= res_ent;
			held_count_q <= skti_pkg::ENT_CNT_W'(count_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_key    = out_ent_q.key;
	assign out_w0     = out_ent_q.w0;
	assign out_w1     = out_ent_q.w1;
	assign out_w2     = out_ent_q.w2;
	assign out_w3     = out_ent_q.w3;
	assign held_count = held_count_q;

endmodule

@@ rtl/skti_cell.sv @@
`timescale 1ns / 1ps
// one table slot: entry storage, key compare flags and shift from the left neighbor
module skti_cell (
	input  logic                         clk,
	input  skti_pkg::cell_ctrl_t         ctrl,
	input  logic                         occ,
	input  logic                         slot_end,
	input  logic [skti_pkg::KEY_W-1:0]   cmp_key,
	input  skti_pkg::entry_t             new_entry,
	input  skti_pkg::entry_t             left_entry,
	input  logic                         left_gt,
	output skti_pkg::entry_t             entry,
	output logic                         gt,
	output logic                         eq
);

	skti_pkg::entry_t entry_q;
	logic             gt_q;
	logic             eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			gt_q <= occ && (entry_q.key > cmp_key);
			eq_q <= occ && (entry_q.key == cmp_key);
		end
		if (ctrl.wr_en) begin
			// left key > new key: shift up, else first larger or end slot takes new entry
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt_q || slot_end) begin
				entry_q <= new_entry;
			end
		end
	end

	assign entry = entry_q;
	assign gt    = gt_q;
	assign eq    = eq_q;

endmodule

@@ rtl/skti_array.sv @@
`timescale 1ns / 1ps
// row of table cells with registered two-level read select and duplicate reduction
module skti_array (
	input  logic                           clk,
	input  skti_pkg::arr_ctrl_t            ctrl,
	input  logic [skti_pkg::CNT_W-1:0]     count,
	input  logic [skti_pkg::KEY_W-1:0]     cmp_key,
	input  skti_pkg::entry_t               new_entry,
	input  logic [skti_pkg::RADDR_W-1:0]   rd_addr,
	output skti_pkg::entry_t               rd_entry,
	output logic                           dup_found
);

	skti_pkg::entry_t                   cell_ent [skti_pkg::DEPTH];
	logic [skti_pkg::DEPTH-1:0]         cell_gt;
	logic [skti_pkg::DEPTH-1:0]         cell_eq;
	skti_pkg::cell_ctrl_t               cctrl;

	skti_pkg::entry_t                   grp_ent [skti_pkg::NGRP_P2][skti_pkg::GRP];
	logic [skti_pkg::GRP-1:0]           grp_eq [skti_pkg::NGRP_P2];

	skti_pkg::entry_t                   rd_grp_s2 [skti_pkg::NGRP_P2];
	skti_pkg::entry_t                   rd_data_s3;
	logic [skti_pkg::NGRP_P2-1:0]       dup_grp_s3;

	logic [skti_pkg::GRP_W-1:0]         rd_lo;
	logic [skti_pkg::SEL_W-1:0]         rd_hi;

	assign cctrl.cmp_en = ctrl.s1_en;
	assign cctrl.wr_en  = ctrl.wr_en;

	assign rd_lo = rd_addr[skti_pkg::GRP_W-1:0];
	assign rd_hi = rd_addr[skti_pkg::RADDR_W-1:skti_pkg::GRP_W];

	for (genvar i = 0; i < skti_pkg::DEPTH; i++) begin : g_cell
		logic             occ;
		logic             slot_end;
		skti_pkg::entry_t left_ent;
		logic             left_gt;

		assign occ      = (skti_pkg::CNT_W'(i) < count);
		assign slot_end = (skti_pkg::CNT_W'(i) == count);

		if (i == 0) begin : g_head
			assign left_ent = '0;
			assign left_gt  = 1'b0;
		end else begin : g_link
			assign left_ent = cell_ent[i-1];
			assign left_gt  = cell_gt[i-1];
		end

		skti_cell u_cell (
			.clk        (clk),
			.ctrl       (cctrl),
			.occ        (occ),
			.slot_end   (slot_end),
			.cmp_key    (cmp_key),
			.new_entry  (new_entry),
			.left_entry (left_ent),
			.left_gt    (left_gt),
			.entry      (cell_ent[i]),
			.gt         (cell_gt[i]),
			.eq         (cell_eq[i])
		);
	end

	// map the row onto a full grid, missing slots read as zero
	for (genvar g = 0; g < skti_pkg::NGRP_P2; g++) begin : g_grp
		for (genvar j = 0; j < skti_pkg::GRP; j++) begin : g_slot
			if (g * skti_pkg::GRP + j < skti_pkg::DEPTH) begin : g_real
				assign grp_ent[g][j] = cell_ent[g * skti_pkg::GRP + j];
				assign grp_eq[g][j]  = cell_eq[g * skti_pkg::GRP + j];
			end else begin : g_pad
				assign grp_ent[g][j] = '0;
				assign grp_eq[g][j]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.s1_en) begin
			for (int g = 0; g < skti_pkg::NGRP_P2; g++) begin
				rd_grp_s2[g] <= grp_ent[g][rd_lo];
			end
		end
		if (ctrl.s2_en) begin
			rd_data_s3 <= rd_grp_s2[rd_hi];
			for (int g = 0; g < skti_pkg::NGRP_P2; g++) begin
				dup_grp_s3[g] <= |grp_eq[g];
			end
		end
	end

	assign rd_entry  = rd_data_s3;
	assign dup_found = |dup_grp_s3;

endmodule
